[rtl/lsgf_pkg.sv]
// Shared types, constants and table layout for the lattice site generate filter.
package lsgf_pkg;

   // Default sizes of the block.
   localparam int LSGF_TABLE_WORDS = 64;
   localparam int LSGF_MAX_BASIS   = 8;
   localparam int LSGF_MAX_TYPES   = 8;
   localparam int LSGF_FRAC_BITS   = 16;

   // Fixed word addresses of the coefficient table.
   localparam int W_MAT   = 0;
   localparam int W_SHIFT = 9;
   localparam int W_BOX   = 12;
   localparam int W_P1    = 15;
   localparam int W_P2    = 19;
   localparam int W_MASS  = 23;

   // Channel widths.
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 168;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_EPSILON   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUT_ONE_MODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUT_TWO_MODE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_OVERRIDE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_NUMBER  = 3'd4;

   // Item kinds carried in tuser.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_GEN  = 1'b1;

   // Cut plane modes.
   localparam logic [1:0] CUT_OFF = 2'd0;
   localparam logic [1:0] CUT_LE  = 2'd1;
   localparam logic [1:0] CUT_GE  = 2'd2;

   // Number of multiply steps for the position: two per matrix column.
   localparam int MUL_STEPS = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_RDM,
      ST_MUL,
      ST_ACC,
      ST_BOX,
      ST_PM,
      ST_PS,
      ST_PT,
      ST_FIN
   } lsgf_state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_CELL,
      MUL_FRAC,
      MUL_PLANE
   } lsgf_mul_op_type;

   typedef enum logic {
      RD_BASIS,
      RD_MASS
   } lsgf_rd_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE,
      CAP_FRAC,
      CAP_TYPE,
      CAP_MASS
   } lsgf_cap_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            start;
      logic            rd_en;
      lsgf_rd_sel_type rd_sel;
      logic [1:0]      rd_word;
      lsgf_cap_type    cap;
      logic [1:0]      cap_word;
      lsgf_mul_op_type mul_op;
      logic [1:0]      mul_col;
      logic            mul_plane;
      logic            box_en;
      logic            out_load;
   } lsgf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_gen;
      logic basis_ok;
      logic keep;
      logic out_free;
   } lsgf_status_type;

endpackage

[rtl/lsgf_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module lsgf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lsgf_ctrl.sv]
// Controller state machine that sequences table reads, multiplies and the keep decision.
module lsgf_ctrl
   import lsgf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  lsgf_status_type status,
   output lsgf_cmd_type    cmd
);

   lsgf_state_type state_ff, state_in;
   logic [2:0]     step_ff, step_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (!status.is_gen) begin
                  cmd.load = 1'b1;
               end else if (status.basis_ok) begin
                  cmd.start = 1'b1;
                  state_in  = ST_RD0;
               end
            end
         end
         ST_RD0: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_BASIS;
            cmd.rd_word = 2'd0;
            state_in    = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_BASIS;
            cmd.rd_word  = 2'd1;
            cmd.cap      = CAP_FRAC;
            cmd.cap_word = 2'd0;
            state_in     = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_BASIS;
            cmd.rd_word  = 2'd2;
            cmd.cap      = CAP_FRAC;
            cmd.cap_word = 2'd1;
            state_in     = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_BASIS;
            cmd.rd_word  = 2'd3;
            cmd.cap      = CAP_FRAC;
            cmd.cap_word = 2'd2;
            state_in     = ST_RDM;
         end
         ST_RDM: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MASS;
            cmd.cap    = CAP_TYPE;
            step_in    = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            // Even steps take matrix times cell, odd steps matrix times basis offset.
            cmd.mul_op  = step_ff[0] ? MUL_FRAC : MUL_CELL;
            cmd.mul_col = step_ff[2:1];
            if (step_ff == '0) begin
               cmd.cap = CAP_MASS;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(MUL_STEPS - 1)) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            state_in = ST_BOX;
         end
         ST_BOX: begin
            cmd.box_en = 1'b1;
            state_in   = ST_PM;
         end
         ST_PM: begin
            cmd.mul_op    = MUL_PLANE;
            cmd.mul_plane = 1'b0;
            state_in      = ST_PS;
         end
         ST_PS: begin
            cmd.mul_op    = MUL_PLANE;
            cmd.mul_plane = 1'b1;
            state_in      = ST_PT;
         end
         ST_PT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!status.keep) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/lsgf_datapath.sv]
// Datapath: coefficient table, configuration registers, shared multipliers and result register.
module lsgf_datapath
   import lsgf_pkg::*;
#(
   parameter int TABLE_WORDS = LSGF_TABLE_WORDS,
   parameter int MAX_BASIS   = LSGF_MAX_BASIS,
   parameter int MAX_TYPES   = LSGF_MAX_TYPES,
   parameter int FRAC_BITS   = LSGF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lsgf_cmd_type           cmd,
   output lsgf_status_type        status,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int AW      = $clog2(TABLE_WORDS);
   localparam int W_BASIS = W_MASS + MAX_TYPES;
   localparam int BA_W    = $clog2(TABLE_WORDS + W_BASIS + 4 * MAX_BASIS);
   localparam int TI_W    = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
   localparam int TERM_W  = (64 - FRAC_BITS > 48) ? 64 - FRAC_BITS : 48;
   localparam int ACC_W   = TERM_W + 3;
   localparam int DOT_W   = 64 - FRAC_BITS + 2;
   localparam int SHADOW  = W_MASS;

   // Input fields.
   logic        [5:0]  req_word_index;
   logic signed [31:0] req_word_value;
   logic signed [15:0] req_cell [3];
   logic        [2:0]  req_basis;

   assign req_word_index = req_tdata[5:0];
   assign req_word_value = req_tdata[37:6];
   assign req_cell[0]    = req_tdata[53:38];
   assign req_cell[1]    = req_tdata[69:54];
   assign req_cell[2]    = req_tdata[85:70];
   assign req_basis      = req_tdata[88:86];

   // Configuration registers.
   logic [15:0] eps_ff;
   logic [1:0]  cut_one_ff;
   logic [1:0]  cut_two_ff;
   logic [8:0]  ovr_ff;
   logic [30:0] start_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff     <= '0;
         cut_one_ff <= CUT_OFF;
         cut_two_ff <= CUT_OFF;
         ovr_ff     <= '1;
         start_ff   <= 31'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_EPSILON:   eps_ff     <= csr_data[15:0];
            CSR_CUT_ONE_MODE:  cut_one_ff <= csr_data[1:0];
            CSR_CUT_TWO_MODE:  cut_two_ff <= csr_data[1:0];
            CSR_TYPE_OVERRIDE: ovr_ff     <= csr_data[8:0];
            CSR_START_NUMBER:  start_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Status on the request side.
   assign status.is_gen   = (req_tuser == FUNC_GEN);
   assign status.basis_ok = (32'(req_basis) < 32'(MAX_BASIS));

   // Register copy of the fixed-address words (matrix, shift, box, planes).
   logic signed [31:0] coef_ff [SHADOW];
   logic signed [31:0] coef_in [SHADOW];

   always_comb begin
      coef_in = coef_ff;
      for (int i = 0; i < SHADOW; i++) begin
         if (cmd.load && (req_word_index == 6'(i))) begin
            coef_in[i] = req_word_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   // Site registers latched at the start of a generate transaction.
   logic signed [15:0] cell_ff [3];
   logic signed [15:0] cell_in [3];
   logic        [2:0]  basis_ff, basis_in;

   always_comb begin
      cell_in  = cell_ff;
      basis_in = basis_ff;
      if (cmd.start) begin
         cell_in  = req_cell;
         basis_in = req_basis;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff  <= cell_in;
      basis_ff <= basis_in;
   end

   // Table memory and its read addressing.
   logic [BA_W-1:0] basis_addr;
   logic            basis_in_table;
   logic [AW-1:0]   mass_addr;
   logic [AW-1:0]   rd_addr;
   logic [31:0]     ram_rdata;
   logic [31:0]     ram_word;
   logic            rd_ok_ff, rd_ok_in;

   assign basis_addr     = BA_W'(W_BASIS) + BA_W'({basis_ff, 2'b00}) + BA_W'(cmd.rd_word);
   assign basis_in_table = (basis_addr < BA_W'(TABLE_WORDS));
   assign ram_word       = rd_ok_ff ? ram_rdata : '0;
   assign mass_addr      = AW'(W_MASS) + AW'(ram_word[TI_W-1:0]);
   assign rd_addr        = (cmd.rd_sel == RD_MASS) ? mass_addr : basis_addr[AW-1:0];

   always_comb begin
      rd_ok_in = rd_ok_ff;
      if (cmd.rd_en) begin
         rd_ok_in = (cmd.rd_sel == RD_MASS) ? 1'b1 : basis_in_table;
      end
   end

   always_ff @(posedge clock) begin
      rd_ok_ff <= rd_ok_in;
   end

   lsgf_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (AW'(req_word_index)),
      .wr_data (req_word_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Capture of basis offsets, basis type and mass.
   logic signed [31:0] frac_ff [3];
   logic signed [31:0] frac_in [3];
   logic        [7:0]  type_lo_ff, type_lo_in;
   logic               mass_ok_ff, mass_ok_in;
   logic        [30:0] mass_ff, mass_in;

   always_comb begin
      frac_in    = frac_ff;
      type_lo_in = type_lo_ff;
      mass_ok_in = mass_ok_ff;
      mass_in    = mass_ff;
      unique case (cmd.cap)
         CAP_FRAC: begin
            frac_in[cmd.cap_word] = ram_word;
         end
         CAP_TYPE: begin
            type_lo_in = ram_word[7:0];
            mass_ok_in = !ram_word[31] && (ram_word < 32'(MAX_TYPES));
         end
         CAP_MASS: begin
            mass_in = (mass_ok_ff && !ram_word[31]) ? ram_word[30:0] : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      frac_ff    <= frac_in;
      type_lo_ff <= type_lo_in;
      mass_ok_ff <= mass_ok_in;
      mass_ff    <= mass_in;
   end

   // Three shared multipliers, one per row in the position phase, one per axis for the planes.
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] mul_a [3];
   logic signed [31:0] mul_b [3];
   logic signed [63:0] prod_ff [3];
   logic signed [63:0] prod_in [3];
   logic signed [63:0] prod_shr [3];
   lsgf_mul_op_type    prod_op_ff, prod_op_in;
   logic               prod_plane_ff, prod_plane_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         if (cmd.mul_op == MUL_PLANE) begin
            mul_a[r] = cmd.mul_plane ? coef_ff[W_P2 + r] : coef_ff[W_P1 + r];
            mul_b[r] = pos_ff[r];
         end else begin
            unique case (cmd.mul_col)
               2'd0: begin
                  mul_a[r] = coef_ff[W_MAT + 3 * r];
                  mul_b[r] = (cmd.mul_op == MUL_FRAC) ? frac_ff[0] : 32'(cell_ff[0]);
               end
               2'd1: begin
                  mul_a[r] = coef_ff[W_MAT + 3 * r + 1];
                  mul_b[r] = (cmd.mul_op == MUL_FRAC) ? frac_ff[1] : 32'(cell_ff[1]);
               end
               default: begin
                  mul_a[r] = coef_ff[W_MAT + 3 * r + 2];
                  mul_b[r] = (cmd.mul_op == MUL_FRAC) ? frac_ff[2] : 32'(cell_ff[2]);
               end
            endcase
         end
         prod_in[r]  = mul_a[r] * mul_b[r];
         prod_shr[r] = prod_ff[r] >>> FRAC_BITS;
      end
      prod_op_in    = cmd.mul_op;
      prod_plane_in = cmd.mul_plane;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_op_ff <= MUL_NONE;
      end else begin
         prod_op_ff <= prod_op_in;
      end
      prod_ff       <= prod_in;
      prod_plane_ff <= prod_plane_in;
   end

   // Row accumulators: start from the shift, then add each registered product.
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [ACC_W-1:0] acc_in [3];

   always_comb begin
      acc_in = acc_ff;
      for (int r = 0; r < 3; r++) begin
         if (cmd.start) begin
            acc_in[r] = ACC_W'(coef_ff[W_SHIFT + r]);
         end else if (prod_op_ff == MUL_CELL) begin
            acc_in[r] = acc_ff[r] + ACC_W'(prod_ff[r]);
         end else if (prod_op_ff == MUL_FRAC) begin
            acc_in[r] = acc_ff[r] + ACC_W'(prod_shr[r]);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Box test on the wide value and saturation to 32 bits.
   logic signed [ACC_W-1:0] box_t [3];
   logic        [2:0]       box_axis_ok;
   logic                    box_ok_ff, box_ok_in;
   logic                    pos_fits [3];

   always_comb begin
      pos_in    = pos_ff;
      box_ok_in = box_ok_ff;
      for (int r = 0; r < 3; r++) begin
         box_t[r]       = acc_ff[r] + ACC_W'(signed'({1'b0, eps_ff}));
         box_axis_ok[r] = !box_t[r][ACC_W-1] && (box_t[r] < ACC_W'(coef_ff[W_BOX + r]));
         pos_fits[r]    = (&acc_ff[r][ACC_W-1:31]) || !(|acc_ff[r][ACC_W-1:31]);
      end
      if (cmd.box_en) begin
         box_ok_in = &box_axis_ok;
         for (int r = 0; r < 3; r++) begin
            if (pos_fits[r]) begin
               pos_in[r] = acc_ff[r][31:0];
            end else if (acc_ff[r][ACC_W-1]) begin
               pos_in[r] = 32'sh8000_0000;
            end else begin
               pos_in[r] = 32'sh7FFF_FFFF;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ok_ff <= box_ok_in;
      pos_ff    <= pos_in;
   end

   // Plane dot products, summed from the registered per-axis products.
   logic signed [DOT_W-1:0] dot_ff [2];
   logic signed [DOT_W-1:0] dot_in [2];
   logic signed [DOT_W-1:0] cut_dist [2];
   logic        [1:0]       plane_mode [2];
   logic        [1:0]       plane_cut;

   always_comb begin
      dot_in = dot_ff;
      if (prod_op_ff == MUL_PLANE) begin
         dot_in[prod_plane_ff] = DOT_W'(prod_shr[0]) + DOT_W'(prod_shr[1])
                               + DOT_W'(prod_shr[2]);
      end
   end

   always_ff @(posedge clock) begin
      dot_ff <= dot_in;
   end

   // Cut decisions and the keep status.
   assign cut_dist[0]   = DOT_W'(coef_ff[W_P1 + 3]);
   assign cut_dist[1]   = DOT_W'(coef_ff[W_P2 + 3]);
   assign plane_mode[0] = cut_one_ff;
   assign plane_mode[1] = cut_two_ff;

   always_comb begin
      for (int p = 0; p < 2; p++) begin
         unique case (plane_mode[p])
            CUT_LE:  plane_cut[p] = (dot_ff[p] <= cut_dist[p]);
            CUT_GE:  plane_cut[p] = (dot_ff[p] >= cut_dist[p]);
            default: plane_cut[p] = 1'b0;
         endcase
      end
   end

   assign status.keep = box_ok_ff && !(|plane_cut);

   // Result register and kept-site count.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [31:0]           count_ff, count_in;
   logic [31:0]           site_number;
   logic [7:0]            site_type;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign site_number     = {1'b0, start_ff} + count_ff;
   assign site_type       = ovr_ff[8] ? type_lo_ff : ovr_ff[7:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      count_in     = count_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, pos_ff[2], pos_ff[1], pos_ff[0], mass_ff, site_type,
                         site_number};
         count_in     = count_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/lattice_site_generate_filter.sv]
// Top level of the lattice site generate filter: controller and datapath.
// A load transaction completes in the idle state. A generate transaction occupies the controller
// until its result is registered or dropped, and the next item is accepted only after that,
// paced by five reads from the single table port and eight passes through the three shared multipliers.
// A waiting result that is held off by rsp_tready also delays acceptance of the next item.
// Reset clears the controller, result valid flag, kept-site count and configuration registers.
module lattice_site_generate_filter
   import lsgf_pkg::*;
#(
   parameter int TABLE_WORDS = LSGF_TABLE_WORDS,
   parameter int MAX_BASIS   = LSGF_MAX_BASIS,
   parameter int MAX_TYPES   = LSGF_MAX_TYPES,
   parameter int FRAC_BITS   = LSGF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // word_index, word_value, cell_i, cell_j, cell_k, basis_index, zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // func
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // site_number, site_type, site_mass, pos_x, pos_y, pos_z, zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   lsgf_cmd_type    cmd;
   lsgf_status_type status;

   // Sequencer.
   lsgf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic, table and result register.
   lsgf_datapath #(
      .TABLE_WORDS (TABLE_WORDS),
      .MAX_BASIS   (MAX_BASIS),
      .MAX_TYPES   (MAX_TYPES),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[tb/sv/lsgf_site_checker.sv]
// Watches the channels of the lattice site generate filter, predicts each kept site and compares.
module lsgf_site_checker
   import lsgf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // word_index, word_value, cell_i, cell_j, cell_k, basis_index, zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // func
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // site_number, site_type, site_mass, pos_x, pos_y, pos_z, zero fill
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     sites_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     BASIS_BASE = W_MASS + LSGF_MAX_TYPES;
   localparam longint POS_MAX    = 64'sh7FFF_FFFF;
   localparam longint POS_MIN    = -64'sh8000_0000;

   typedef struct packed {
      logic [31:0] number;
      logic [7:0]  atom_type;
      logic [30:0] mass;
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
   } site_rec_type;

   // Own copy of the coefficient table, the kept-site count and the registers.
   logic [31:0] coeff_words [0:LSGF_TABLE_WORDS-1];
   logic [31:0] sites_kept;
   logic [15:0] cfg_eps;
   logic [1:0]  cfg_cut_one;
   logic [1:0]  cfg_cut_two;
   logic [8:0]  cfg_override;
   logic [30:0] cfg_start;

   site_rec_type predicted_sites [$];
   int           results_seen;

   // True when an enabled cut plane removes the saturated position.
   function automatic bit plane_cuts(input logic [1:0] mode, input int base,
                                     input longint p [3]);
      longint dot;
      longint plane_dist;
      if (mode != CUT_LE && mode != CUT_GE)
         return 1'b0;
      dot = 0;
      for (int c = 0; c < 3; c++)
         dot += (longint'($signed(coeff_words[base + c])) * p[c]) >>> LSGF_FRAC_BITS;
      plane_dist = longint'($signed(coeff_words[base + 3]));
      return (mode == CUT_LE) ? (dot <= plane_dist) : (dot >= plane_dist);
   endfunction

   // Maps one generate transaction to a site; returns whether the site is kept.
   function automatic bit place_site(input logic [REQ_DATA_W-1:0] d, output site_rec_type s);
      longint ijk [3];
      longint frac [3];
      longint wide [3];
      longint pos [3];
      longint m;
      longint t;
      longint btype;
      longint massv;
      int     base;
      bit     keep;
      ijk[0] = longint'($signed(d[53:38]));
      ijk[1] = longint'($signed(d[69:54]));
      ijk[2] = longint'($signed(d[85:70]));
      base = BASIS_BASE + 4 * int'(d[88:86]);
      for (int c = 0; c < 3; c++)
         frac[c] = longint'($signed(coeff_words[base + c]));

      // Exact integer part plus floored fractional part, held wide.
      for (int r = 0; r < 3; r++) begin
         wide[r] = longint'($signed(coeff_words[W_SHIFT + r]));
         for (int c = 0; c < 3; c++) begin
            m = longint'($signed(coeff_words[W_MAT + 3 * r + c]));
            wide[r] += m * ijk[c] + ((m * frac[c]) >>> LSGF_FRAC_BITS);
         end
      end

      // Box test on the wide value, then saturation to 32 bits.
      keep = 1'b1;
      for (int r = 0; r < 3; r++) begin
         t = wide[r] + longint'(cfg_eps);
         if (t < 0 || t >= longint'($signed(coeff_words[W_BOX + r])))
            keep = 1'b0;
         if (wide[r] > POS_MAX)
            pos[r] = POS_MAX;
         else if (wide[r] < POS_MIN)
            pos[r] = POS_MIN;
         else
            pos[r] = wide[r];
      end
      if (keep && plane_cuts(cfg_cut_one, W_P1, pos))
         keep = 1'b0;
      if (keep && plane_cuts(cfg_cut_two, W_P2, pos))
         keep = 1'b0;

      // Type from the override when it is not negative; mass always by the basis type.
      if (!cfg_override[8])
         s.atom_type = cfg_override[7:0];
      else
         s.atom_type = coeff_words[base + 3][7:0];
      btype = longint'($signed(coeff_words[base + 3]));
      massv = 0;
      if (btype >= 0 && btype < LSGF_MAX_TYPES) begin
         massv = longint'($signed(coeff_words[W_MASS + int'(btype)]));
         if (massv < 0)
            massv = 0;
      end
      s.mass   = massv[30:0];
      s.number = {1'b0, cfg_start} + sites_kept;
      s.px     = pos[0][31:0];
      s.py     = pos[1][31:0];
      s.pz     = pos[2][31:0];
      return keep;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch in %s of result %0d: expected %h, got %h",
                     label, results_seen, want, got);
      end
   endfunction

   // Everything is sampled at the rising edge; results are compared before new items go in.
   always @(posedge clock) begin
      site_rec_type want;
      site_rec_type got;
      if (reset) begin
         sites_kept   = '0;
         cfg_eps      = '0;
         cfg_cut_one  = CUT_OFF;
         cfg_cut_two  = CUT_OFF;
         cfg_override = 9'h1FF;
         cfg_start    = 31'd1;
         mismatches   = 0;
         results_seen = 0;
         predicted_sites.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.number    = rsp_tdata[31:0];
            got.atom_type = rsp_tdata[39:32];
            got.mass      = rsp_tdata[70:40];
            got.px        = rsp_tdata[102:71];
            got.py        = rsp_tdata[134:103];
            got.pz        = rsp_tdata[166:135];
            if (predicted_sites.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %0d: number %h, position %h %h %h",
                           results_seen, got.number, got.px, got.py, got.pz);
            end else begin
               want = predicted_sites.pop_front();
               check_field("site_number", want.number, got.number);
               check_field("site_type", {24'd0, want.atom_type}, {24'd0, got.atom_type});
               check_field("site_mass", {1'b0, want.mass}, {1'b0, got.mass});
               check_field("pos_x", want.px, got.px);
               check_field("pos_y", want.py, got.py);
               check_field("pos_z", want.pz, got.pz);
            end
            results_seen++;
         end

         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BOX_EPSILON:   cfg_eps      = csr_data[15:0];
               CSR_CUT_ONE_MODE:  cfg_cut_one  = csr_data[1:0];
               CSR_CUT_TWO_MODE:  cfg_cut_two  = csr_data[1:0];
               CSR_TYPE_OVERRIDE: cfg_override = csr_data[8:0];
               CSR_START_NUMBER:  cfg_start    = csr_data[30:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_LOAD)
               coeff_words[req_tdata[5:0]] = req_tdata[37:6];
            else if (place_site(req_tdata, want)) begin
               predicted_sites.push_back(want);
               sites_kept = sites_kept + 32'd1;
            end
         end
      end
      sites_pending = predicted_sites.size();
   end

endmodule

[tb/sv/lattice_site_generate_filter_tb.sv]
// Testbench top for the lattice site generate filter: clock, reset, stimulus and verdict.
module lattice_site_generate_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsgf_pkg::*;

   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         PHASES          = 12;
   localparam int         SITES_PER_PHASE = 75;
   localparam int         SETTLE_CYCLES   = 30;
   localparam int         BASIS_BASE      = W_MASS + LSGF_MAX_TYPES;
   // Cut mode code with no meaning; the block treats it as off.
   localparam logic [1:0] CUT_SPARE       = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = FUNC_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BOX_EPSILON;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   int                     mismatches;
   int                     sites_pending;
   int                     cycle_count = 0;
   int                     stall_left  = 0;
   bit                     gaps_on     = 1'b1;

   lattice_site_generate_filter uut (.*);
   lsgf_site_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Result side back-pressure in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (gaps_on && $urandom_range(0, 9) == 0)
         stall_left = $urandom_range(1, 7);
      rsp_tready = (stall_left == 0);
   end

   function automatic logic [REQ_DATA_W-1:0] pack_req(
      input logic [5:0] idx, input logic [31:0] val,
      input logic [15:0] ci, input logic [15:0] cj, input logic [15:0] ck,
      input logic [2:0] b);
      return {7'd0, b, ck, cj, ci, val, idx};
   endfunction

   // Plausible table contents: a near-diagonal lattice, a modest box and sensible basis atoms.
   function automatic logic [31:0] crystal_word(input int idx);
      int w;
      if (idx < W_SHIFT) begin
         if (idx / 3 == idx % 3)
            return $urandom_range(32'h8000, 32'h40000);
         if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 32'h8000) - 32'h4000;
         return 32'd0;
      end
      if (idx < W_BOX)
         return $urandom_range(0, 32'h40000) - 32'h20000;
      if (idx < W_P1)
         return $urandom_range(32'h40000, 32'h400000);
      if (idx < W_MASS) begin
         if (idx == W_P1 + 3 || idx == W_P2 + 3)
            return $urandom_range(0, 32'h400000) - 32'h200000;
         return $urandom_range(0, 32'h20000) - 32'h10000;
      end
      if (idx < BASIS_BASE) begin
         case ($urandom_range(0, 7))
            0:       return 32'h8000_0000 | $urandom;
            1:       return $urandom_range(0, 32'h7FFF_FFFF);
            default: return $urandom_range(0, 32'h00C8_0000);
         endcase
      end
      if (idx < BASIS_BASE + 4 * LSGF_MAX_BASIS) begin
         w = (idx - BASIS_BASE) % 4;
         if (w < 3) begin
            if ($urandom_range(0, 9) == 0)
               return $urandom_range(0, 32'h60000) - 32'h30000;
            return $urandom_range(0, 16'hFFFF);
         end
         case ($urandom_range(0, 9))
            0:       return 32'd0 - $urandom_range(1, 4);
            1:       return $urandom_range(LSGF_MAX_TYPES, 300);
            2:       return $urandom;
            default: return $urandom_range(0, LSGF_MAX_TYPES - 1);
         endcase
      end
      return $urandom;
   endfunction

   // Phase zero takes the low end, phase one the high end, later phases a mix.
   function automatic logic [31:0] pick_value(input int p, input logic [31:0] lo,
                                              input logic [31:0] hi, input logic [31:0] any);
      if (p == 0)
         return lo;
      if (p == 1)
         return hi;
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return any;
      endcase
   endfunction

   // One input transaction, with an optional gap before it; valid stays high afterwards.
   task automatic send_item(input logic func, input logic [REQ_DATA_W-1:0] data);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Loads carry random cell fields and generates random word fields; the block ignores them.
   task automatic load_word(input int idx, input logic [31:0] val);
      send_item(FUNC_LOAD, pack_req(6'(idx), val, 16'($urandom), 16'($urandom),
                                    16'($urandom), 3'($urandom)));
   endtask

   task automatic gen_site(input logic [15:0] ci, input logic [15:0] cj,
                           input logic [15:0] ck, input logic [2:0] b);
      send_item(FUNC_GEN, pack_req(6'($urandom), $urandom, ci, cj, ck, b));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits until every predicted site has come out and a rejected site has had time to finish.
   task automatic settle();
      req_tvalid = 1'b0;
      while (sites_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int          pick;
      int          idx;
      logic [1:0]  cut_one;
      logic [1:0]  cut_two;
      logic [31:0] val;

      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Directed part: full table, basis sweep, field extremes and the special cases.
      write_reg(CSR_BOX_EPSILON, 31'h0000_FFFF);
      for (idx = 0; idx < LSGF_TABLE_WORDS; idx++)
         load_word(idx, crystal_word(idx));
      for (idx = 0; idx < 3; idx++)
         load_word(W_BOX + idx, 32'h7FFF_FFFF);
      for (idx = 0; idx < LSGF_MAX_BASIS; idx++)
         gen_site(16'd2, 16'd2, 16'd2, 3'(idx));
      gen_site(16'd0, 16'd0, 16'd0, 3'd0);
      gen_site(16'h7FFF, 16'h7FFF, 16'h7FFF, 3'd7);
      gen_site(16'h8000, 16'h8000, 16'h8000, 3'd0);
      // Negative mass word, type word of zero, type word of minus one, type past the mass list.
      load_word(W_MASS, 32'h8000_0001);
      load_word(BASIS_BASE + 4 + 3, 32'd0);
      load_word(BASIS_BASE + 8 + 3, 32'hFFFF_FFFF);
      load_word(BASIS_BASE + 12 + 3, LSGF_MAX_TYPES);
      gen_site(16'd2, 16'd2, 16'd2, 3'd1);
      gen_site(16'd2, 16'd2, 16'd2, 3'd2);
      gen_site(16'd2, 16'd2, 16'd2, 3'd3);
      gen_site(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd3);
      // Extreme matrix words with extreme cells: products far beyond 32 bits.
      load_word(W_MAT, 32'h7FFF_FFFF);
      load_word(W_MAT + 4, 32'h8000_0000);
      gen_site(16'h7FFF, 16'h8000, 16'h7FFF, 3'd7);
      gen_site(16'h8000, 16'h7FFF, 16'h8000, 3'd0);

      // Random phases, each with its own register settings and table contents.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         gaps_on = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
         cut_one = 2'(pick_value(p, CUT_OFF, CUT_GE, $urandom_range(0, 3)));
         cut_two = 2'(pick_value(p, CUT_OFF, CUT_GE, $urandom_range(0, 3)));
         if (p == 2) begin
            cut_one = CUT_LE;
            cut_two = CUT_SPARE;
         end else if (p == 3) begin
            cut_one = CUT_SPARE;
            cut_two = CUT_LE;
         end
         write_reg(CSR_BOX_EPSILON, 31'(pick_value(p, 0, 16'hFFFF, $urandom_range(0, 16'hFFFF))));
         write_reg(CSR_CUT_ONE_MODE, 31'(cut_one));
         write_reg(CSR_CUT_TWO_MODE, 31'(cut_two));
         write_reg(CSR_TYPE_OVERRIDE, 31'(9'(pick_value(p, 9'h1FF, 9'd255, $urandom))));
         write_reg(CSR_START_NUMBER, 31'(pick_value(p, 0, 31'h7FFF_FFFF, $urandom)));

         if (p % 2 == 0) begin
            for (idx = 0; idx < LSGF_TABLE_WORDS; idx++)
               load_word(idx, crystal_word(idx));
         end else begin
            repeat (12) begin
               idx = $urandom_range(0, LSGF_TABLE_WORDS - 1);
               load_word(idx, crystal_word(idx));
            end
         end

         // Mostly sites in a small cell range, with noise sites and stray table loads.
         for (int n = 0; n < SITES_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) begin
               gen_site(16'($urandom_range(0, 10) - 1), 16'($urandom_range(0, 10) - 1),
                        16'($urandom_range(0, 10) - 1), 3'($urandom));
            end else if (pick < 93) begin
               gen_site(16'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
            end else begin
               idx = $urandom_range(0, LSGF_TABLE_WORDS - 1);
               val = $urandom_range(0, 1) ? crystal_word(idx) : $urandom;
               load_word(idx, val);
            end
         end
      end

      settle();
      if (mismatches == 0 && sites_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
